// ===== sv/lfnr_pkg.sv =====
`default_nettype none

package lfnr_pkg;

    localparam int MAX_DIGITS_DEF = 18;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 60;
    localparam int MANT_W  = 61;
    localparam int FRAC_W  = 5;
    localparam int COUNT_W = 5;
    localparam int POS_W   = 6;
    localparam int DIGIT_W = 4;

    localparam logic [POS_W-1:0]   POS_NONE      = '1;
    localparam logic [COUNT_W-1:0] COUNT_CAP     = '1;
    localparam logic [COUNT_W-1:0] GROUP_DIGITS  = COUNT_W'(3);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h28;
    localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h29;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_NBSP_0 = 8'hC2;
    localparam logic [BYTE_W-1:0] CH_NBSP_1 = 8'hA0;
    localparam logic [BYTE_W-1:0] CH_EURO_0 = 8'hE2;
    localparam logic [BYTE_W-1:0] CH_EURO_1 = 8'h82;
    localparam logic [BYTE_W-1:0] CH_EURO_2 = 8'hAC;

    typedef logic [3:0] t_cls;

    localparam t_cls CLS_DIGIT = 4'd0;
    localparam t_cls CLS_MINUS = 4'd1;
    localparam t_cls CLS_PLUS  = 4'd2;
    localparam t_cls CLS_OPEN  = 4'd3;
    localparam t_cls CLS_CLOSE = 4'd4;
    localparam t_cls CLS_DOT   = 4'd5;
    localparam t_cls CLS_COMMA = 4'd6;
    localparam t_cls CLS_SKIP  = 4'd7;
    localparam t_cls CLS_OTHER = 4'd8;

    typedef struct packed {
        t_cls               cls;
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_item;

    function automatic logic [63:0] pow10(input int n);
        logic [63:0] acc;
        acc = 64'd1;
        for (int k = 0; k < n; k++) begin
            acc = acc * 64'd10;
        end
        return acc;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lfnr_front.sv =====
`default_nettype none

module lfnr_front (
    input  wire logic                       i_valid,
    input  wire logic [lfnr_pkg::BYTE_W-1:0] i_text_byte,
    input  wire logic                       i_has_byte,
    input  wire logic                       i_last,
    input  wire logic                       i_full,
    output logic                            o_stall,
    output logic                            o_push,
    output lfnr_pkg::t_item                 o_item
);
    import lfnr_pkg::*;

    t_cls cls;

    always_comb begin
        cls = CLS_OTHER;
        if (!i_has_byte) begin
            cls = CLS_SKIP;
        end else if (i_text_byte >= CH_ZERO && i_text_byte <= CH_NINE) begin
            cls = CLS_DIGIT;
        end else begin
            unique case (i_text_byte)
                CH_MINUS: cls = CLS_MINUS;
                CH_PLUS:  cls = CLS_PLUS;
                CH_OPEN:  cls = CLS_OPEN;
                CH_CLOSE: cls = CLS_CLOSE;
                CH_DOT:   cls = CLS_DOT;
                CH_COMMA: cls = CLS_COMMA;
                CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_DOLLAR,
                CH_NBSP_0, CH_NBSP_1, CH_EURO_0, CH_EURO_1, CH_EURO_2: cls = CLS_SKIP;
                default:  cls = CLS_OTHER;
            endcase
        end
    end

    assign o_item.cls   = cls;
    assign o_item.digit = i_text_byte[DIGIT_W-1:0];
    assign o_item.last  = i_last;
    assign o_stall      = i_full;
    assign o_push       = i_valid && !i_full;

endmodule

`default_nettype wire

// ===== sv/lfnr_queue.sv =====
`default_nettype none

module lfnr_queue (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire lfnr_pkg::t_item i_item,
    input  wire logic      i_pop,
    output logic           o_valid,
    output lfnr_pkg::t_item o_item,
    output logic           o_full
);
    import lfnr_pkg::*;

    t_item               r_entry [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    logic [QPTR_W-1:0]   n_wr_ptr;
    logic [QPTR_W-1:0]   n_rd_ptr;
    logic [QPTR_W:0]     n_count;
    logic                do_pop;

    assign do_pop  = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_item  = r_entry[r_rd_ptr];
    assign o_full  = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + (QPTR_W+1)'(i_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/lfnr_back.sv =====
`default_nettype none

module lfnr_back #(
    parameter int MAX_DIGITS = lfnr_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_item_valid,
    input  wire lfnr_pkg::t_item                    i_item,
    output logic                                    o_pop,
    output logic                                    o_valid,
    output logic                                    o_is_number,
    output logic signed [lfnr_pkg::MANT_W-1:0]      o_signed_mantissa,
    output logic [lfnr_pkg::FRAC_W-1:0]             o_fraction_digits,
    output logic                                    o_too_many_digits,
    input  wire logic                               i_stall
);
    import lfnr_pkg::*;

    localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_DIGITS);
    localparam logic [VALUE_W-1:0] MAG_SAT = VALUE_W'(pow10(MAX_DIGITS) - 64'd1);

    logic [VALUE_W-1:0] r_value,  n_value;
    logic [COUNT_W-1:0] r_count,  n_count;
    logic               r_minus,  n_minus;
    logic               r_open,   n_open;
    logic [POS_W-1:0]   r_dot,    n_dot;
    logic [POS_W-1:0]   r_comma,  n_comma;
    logic               r_refused, n_refused;

    logic               r_fin_valid;
    logic [VALUE_W-1:0] r_fin_value;
    logic [COUNT_W-1:0] r_fin_count;
    logic               r_fin_minus;
    logic [POS_W-1:0]   r_fin_dot;
    logic [POS_W-1:0]   r_fin_comma;
    logic               r_fin_refused;

    logic               r_out_valid;
    logic               r_is_number;
    logic [MANT_W-1:0]  r_mantissa;
    logic [FRAC_W-1:0]  r_frac;
    logic               r_over;

    logic out_ready;
    logic fin_ready;
    logic pop;

    assign out_ready = !r_out_valid || !i_stall;
    assign fin_ready = !r_fin_valid || out_ready;
    assign pop       = i_item_valid && (!i_item.last || fin_ready);
    assign o_pop     = pop;

    always_comb begin
        n_value   = r_value;
        n_count   = r_count;
        n_minus   = r_minus;
        n_open    = r_open;
        n_dot     = r_dot;
        n_comma   = r_comma;
        n_refused = r_refused;
        if (!r_refused) begin
            unique case (i_item.cls)
                CLS_DIGIT: begin
                    if (r_count < MAX_CNT) begin
                        n_value = (r_value << 3) + (r_value << 1)
                                  + VALUE_W'(i_item.digit);
                    end
                    if (r_count != COUNT_CAP) begin
                        n_count = r_count + 1'b1;
                    end
                end
                CLS_MINUS: begin
                    if (r_count != '0) begin
                        n_refused = 1'b1;
                    end else begin
                        n_minus = 1'b1;
                    end
                end
                CLS_PLUS: begin
                    if (r_count != '0) begin
                        n_refused = 1'b1;
                    end
                end
                CLS_OPEN:  n_open = 1'b1;
                CLS_CLOSE: begin
                    if (r_open) begin
                        n_minus = 1'b1;
                    end
                end
                CLS_DOT:   n_dot   = POS_W'(r_count);
                CLS_COMMA: n_comma = POS_W'(r_count);
                CLS_SKIP:  ;
                default:   n_refused = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value   <= '0;
            r_count   <= '0;
            r_minus   <= 1'b0;
            r_open    <= 1'b0;
            r_dot     <= POS_NONE;
            r_comma   <= POS_NONE;
            r_refused <= 1'b0;
        end else if (pop) begin
            if (i_item.last) begin
                r_value   <= '0;
                r_count   <= '0;
                r_minus   <= 1'b0;
                r_open    <= 1'b0;
                r_dot     <= POS_NONE;
                r_comma   <= POS_NONE;
                r_refused <= 1'b0;
            end else begin
                r_value   <= n_value;
                r_count   <= n_count;
                r_minus   <= n_minus;
                r_open    <= n_open;
                r_dot     <= n_dot;
                r_comma   <= n_comma;
                r_refused <= n_refused;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_valid <= 1'b0;
        end else if (fin_ready) begin
            r_fin_valid <= pop && i_item.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_ready && pop && i_item.last) begin
            r_fin_value   <= n_value;
            r_fin_count   <= n_count;
            r_fin_minus   <= n_minus;
            r_fin_dot     <= n_dot;
            r_fin_comma   <= n_comma;
            r_fin_refused <= n_refused;
        end
    end

    logic               good;
    logic               has_dot;
    logic               has_comma;
    logic [POS_W-1:0]   sep_pos;
    logic [POS_W-1:0]   diff;
    logic [COUNT_W-1:0] after;
    logic [COUNT_W-1:0] frac_raw;
    logic [FRAC_W-1:0]  frac;
    logic               over;
    logic [VALUE_W-1:0] mag;
    logic [MANT_W-1:0]  mant;

    always_comb begin
        good      = !r_fin_refused && (r_fin_count != '0);
        has_dot   = (r_fin_dot != POS_NONE);
        has_comma = (r_fin_comma != POS_NONE);
        if (has_dot && has_comma) begin
            sep_pos = (r_fin_dot > r_fin_comma) ? r_fin_dot : r_fin_comma;
        end else if (has_dot) begin
            sep_pos = r_fin_dot;
        end else begin
            sep_pos = r_fin_comma;
        end
        diff  = POS_W'(r_fin_count) - sep_pos;
        after = diff[COUNT_W-1:0];
        if (has_dot && has_comma) begin
            frac_raw = after;
        end else if (has_dot || has_comma) begin
            frac_raw = (after == GROUP_DIGITS) ? '0 : after;
        end else begin
            frac_raw = '0;
        end
        frac = FRAC_W'((frac_raw > MAX_CNT) ? MAX_CNT : frac_raw);
        over = (r_fin_count > MAX_CNT);
        mag  = over ? MAG_SAT : r_fin_value;
        mant = {1'b0, mag};
        if (r_fin_minus) begin
            mant = -mant;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_fin_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_fin_valid) begin
            r_is_number <= good;
            r_mantissa  <= good ? mant : '0;
            r_frac      <= good ? frac : '0;
            r_over      <= good && over;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_is_number       = r_is_number;
    assign o_signed_mantissa = r_mantissa;
    assign o_fraction_digits = r_frac;
    assign o_too_many_digits = r_over;

endmodule

`default_nettype wire

// ===== sv/locale_free_number_reader_unit.sv =====
// Reads one text field a byte per beat and reports whether it is a number.
// Input channel: i_valid, o_stall and the fields i_text_byte, i_has_byte and
// i_last. A beat is taken at a clock edge with i_valid high and o_stall low.
// i_has_byte low makes an empty beat, which is useful to close a field.
// Output channel: o_valid, i_stall and the fields o_is_number,
// o_signed_mantissa, o_fraction_digits and o_too_many_digits. One result beat
// follows each input beat with i_last high; the value is the mantissa
// divided by ten to the power of o_fraction_digits.
// A byte is classified on entry and queued in a four-entry queue; the back
// end updates the digit accumulator at one beat per cycle, the multiply by
// ten and add of the 60-bit accumulator setting that rate; a last beat
// waits in the queue while the snapshot is full and the output stalled.
// Its result passes through a snapshot register and the output register.
// When i_stall is held, the output holds its beat and the snapshot fills;
// the queue then fills once a last beat waits at its head, and o_stall
// rises once the queue is full. Synchronous reset clears the queue, the field
// state and both valid flags; beats can be taken once reset is released.
`default_nettype none

module locale_free_number_reader_unit #(
    parameter int MAX_DIGITS = lfnr_pkg::MAX_DIGITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [lfnr_pkg::BYTE_W-1:0]        i_text_byte,
    input  wire logic                               i_has_byte,
    input  wire logic                               i_last,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic                                    o_is_number,
    output logic signed [lfnr_pkg::MANT_W-1:0]      o_signed_mantissa,
    output logic [lfnr_pkg::FRAC_W-1:0]             o_fraction_digits,
    output logic                                    o_too_many_digits
);
    import lfnr_pkg::*;

    logic  push;
    logic  full;
    logic  pop;
    logic  q_valid;
    t_item front_item;
    t_item q_item;

    lfnr_front u_front (
        .i_valid     (i_valid),
        .i_text_byte (i_text_byte),
        .i_has_byte  (i_has_byte),
        .i_last      (i_last),
        .i_full      (full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_item      (front_item)
    );

    lfnr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item),
        .o_full  (full)
    );

    lfnr_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_item_valid      (q_valid),
        .i_item            (q_item),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .o_is_number       (o_is_number),
        .o_signed_mantissa (o_signed_mantissa),
        .o_fraction_digits (o_fraction_digits),
        .o_too_many_digits (o_too_many_digits),
        .i_stall           (i_stall)
    );

endmodule

`default_nettype wire

// ===== sv/lfnr_checker.sv =====
`default_nettype none

module lfnr_checker #(
    parameter int MAX_DIGITS = lfnr_pkg::MAX_DIGITS_DEF
) (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                o_valid,
    input wire logic                                i_stall,
    input wire logic                                o_is_number,
    input wire logic signed [lfnr_pkg::MANT_W-1:0]  o_signed_mantissa,
    input wire logic [lfnr_pkg::FRAC_W-1:0]         o_fraction_digits,
    input wire logic                                o_too_many_digits
);
    import lfnr_pkg::*;

    localparam logic [MANT_W-1:0] SAT_POS = MANT_W'(pow10(MAX_DIGITS) - 64'd1);
    localparam logic [MANT_W-1:0] SAT_NEG = -SAT_POS;
    localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(MAX_DIGITS);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat shown straight after reset");

    a_held_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_signed_mantissa)
            && $stable(o_is_number) && $stable(o_fraction_digits))
        else $error("stalled result beat changed");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_number |-> o_signed_mantissa == '0
            && o_fraction_digits == '0 && !o_too_many_digits)
        else $error("refused field carries a value");

    a_frac_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fraction_digits <= FRAC_MAX)
        else $error("fraction digit count beyond the limit");

    a_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_too_many_digits |-> o_is_number
            && (o_signed_mantissa == SAT_POS || o_signed_mantissa == SAT_NEG))
        else $error("overflowing mantissa not saturated");

endmodule

bind locale_free_number_reader_unit lfnr_checker #(
    .MAX_DIGITS (MAX_DIGITS)
) u_lfnr_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_stall           (i_stall),
    .o_is_number       (o_is_number),
    .o_signed_mantissa (o_signed_mantissa),
    .o_fraction_digits (o_fraction_digits),
    .o_too_many_digits (o_too_many_digits)
);

`default_nettype wire
